/* rtl/core/clri_pkg.sv */
// clri_pkg: shared types and constants of the colour ramp interpolator
// holds the item, state and status types used by front, queue and back
// depends on nothing
`default_nettype none

package clri_pkg;

  // fixed point: 1.0 is 2^FRAC_W
  localparam int FRAC_W     = 16;
  localparam int VAL_W      = FRAC_W + 1;
  localparam int SAMPLE_W   = 18;
  localparam int POS_W      = 17;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int COLOR_W    = NUM_CH * CH_W;
  localparam int SLOT_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [VAL_W-1:0] ONE_Q = {1'b1, {FRAC_W{1'b0}}};

  // smallest key gap that still gives a weight, ceil(1.0 / 10000)
  localparam int MIN_GAP = ((1 << FRAC_W) + 9999) / 10000;

  // blend datapath widths
  localparam int W_W    = 32;
  localparam int DIFF_W = CH_W + 1;
  localparam int PROD_W = W_W + DIFF_W;
  localparam int SUM_W  = PROD_W + 1;

  // radix-4 divider: 34-bit dividend, two quotient bits per cycle
  localparam int DIV_N_W   = 34;
  localparam int DIV_STEPS = DIV_N_W / 2;
  localparam int DIV_CNT_W = 5;

  // item queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_MAP   = 1'b0,
    OP_WRITE = 1'b1
  } clri_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COUNT = 2'd0,
    REG_INVERT    = 2'd1
  } clri_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_LO,
    ST_HI,
    ST_DIV,
    ST_WGT,
    ST_MUL,
    ST_SUM
  } clri_state_e;

  // classified item as it waits in the queue
  typedef struct packed {
    clri_op_e           op;
    logic [SLOT_W-1:0]  slot;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   position;
    logic [COLOR_W-1:0] color;
  } clri_item_t;

  // engine status seen by the top level
  typedef struct packed {
    clri_state_e state;
    logic        search_room;
    logic        load_result;
  } clri_status_t;

endpackage

`default_nettype wire

/* rtl/core/clri_front.sv */
// clri_front: accepts items, clamps and inverts the scalar, drops stray key writes
// depends on clri_pkg
`default_nettype none

module clri_front #(
  parameter int MAX_KEYS = 8
) (
  input  logic                                push_i,
  input  logic                                full_i,
  input  logic                                invert_i,
  input  logic                                operation_i,
  input  logic signed [clri_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [clri_pkg::SLOT_W-1:0]         key_slot_i,
  input  logic [clri_pkg::POS_W-1:0]          key_position_i,
  input  logic [clri_pkg::CH_W-1:0]           key_red_i,
  input  logic [clri_pkg::CH_W-1:0]           key_green_i,
  input  logic [clri_pkg::CH_W-1:0]           key_blue_i,
  input  logic [clri_pkg::CH_W-1:0]           key_alpha_i,
  output logic                                enq_o,
  output clri_pkg::clri_item_t                item_o
);

  logic                          slot_ok;
  logic [clri_pkg::VAL_W-1:0]    clamped;
  clri_pkg::clri_op_e            op;

  assign op      = clri_pkg::clri_op_e'(operation_i);
  assign slot_ok = 32'(key_slot_i) < MAX_KEYS;

  // clamp the scalar to 0..1.0
  always_comb begin
    priority if (sample_value_i[clri_pkg::SAMPLE_W-1]) begin
      clamped = '0;
    end else if (sample_value_i[clri_pkg::VAL_W-1:0] > clri_pkg::ONE_Q) begin
      clamped = clri_pkg::ONE_Q;
    end else begin
      clamped = sample_value_i[clri_pkg::VAL_W-1:0];
    end
  end

  // build the queue item
  always_comb begin
    item_o.op       = op;
    item_o.slot     = key_slot_i;
    item_o.value    = invert_i ? (clri_pkg::ONE_Q - clamped) : clamped;
    item_o.position = key_position_i;
    item_o.color    = {key_alpha_i, key_blue_i, key_green_i, key_red_i};
  end

  // writes beyond the key store are accepted and dropped
  assign enq_o = push_i && !full_i && !(op == clri_pkg::OP_WRITE && !slot_ok);

endmodule

`default_nettype wire

/* rtl/core/clri_queue.sv */
// clri_queue: short item queue between front and back
// depends on clri_pkg
`default_nettype none

module clri_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enq_i,
  input  clri_pkg::clri_item_t item_i,
  output logic                 full_o,
  input  logic                 deq_i,
  output logic                 valid_o,
  output clri_pkg::clri_item_t item_o
);

  localparam int PtrW = (clri_pkg::QUEUE_DEPTH > 1) ? $clog2(clri_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(clri_pkg::QUEUE_DEPTH + 1);

  clri_pkg::clri_item_t slot_q [clri_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_enq, do_deq;

  assign full_o  = 32'(cnt_q) == clri_pkg::QUEUE_DEPTH;
  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_enq) begin
      wr_ptr_d = (32'(wr_ptr_q) == clri_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_deq) begin
      rd_ptr_d = (32'(rd_ptr_q) == clri_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_enq && !do_deq) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_deq && !do_enq) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/clri_back.sv */
// clri_back: key store, segment search, radix-4 divider, blend and result register
// depends on clri_pkg
`default_nettype none

module clri_back #(
  parameter int MAX_KEYS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [clri_pkg::COUNT_W-1:0]      count_i,
  input  logic                              q_valid_i,
  input  clri_pkg::clri_item_t              q_item_i,
  output logic                              q_deq_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [clri_pkg::CH_W-1:0]         out_red_o,
  output logic [clri_pkg::CH_W-1:0]         out_green_o,
  output logic [clri_pkg::CH_W-1:0]         out_blue_o,
  output logic [clri_pkg::CH_W-1:0]         out_alpha_o,
  output clri_pkg::clri_status_t            status_o
);

  localparam int IdxW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int PosW    = clri_pkg::POS_W;
  localparam int ValW    = clri_pkg::VAL_W;
  localparam int FracW   = clri_pkg::FRAC_W;
  localparam int ChW     = clri_pkg::CH_W;
  localparam int ColorW  = clri_pkg::COLOR_W;
  localparam int SumW    = clri_pkg::SUM_W;
  localparam int ProdW   = clri_pkg::PROD_W;
  localparam int DivNW   = clri_pkg::DIV_N_W;
  localparam int WW      = clri_pkg::W_W;

  localparam logic signed [SumW-1:0] HalfQ =
    {{(SumW - FracW){1'b0}}, 1'b1, {(FracW - 1){1'b0}}};

  // key store
  logic [PosW-1:0]   pos_mem [MAX_KEYS];
  logic [ColorW-1:0] col_mem [MAX_KEYS];
  logic [MAX_KEYS-1:0] key_vld_q, key_vld_d;
  logic [PosW-1:0]   pos_rd_q;
  logic [ColorW-1:0] col_rd_q;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_addr;
  logic              mem_we;

  // engine state
  clri_pkg::clri_state_e state_q, state_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [ValW-1:0]       v_q, v_d;
  logic                  few_q, few_d;
  logic [PosW-1:0]       p0_q, p0_d;
  logic [PosW-1:0]       p1_q, p1_d;
  logic [ColorW-1:0]     c0_q, c0_d;
  logic [ColorW-1:0]     c1_q, c1_d;

  // divider
  logic [PosW-1:0]                     gap_q, gap_d;
  logic [DivNW-1:0]                    num_q, num_d;
  logic [PosW-1:0]                     rem_q, rem_d;
  logic [DivNW-1:0]                    quo_q, quo_d;
  logic [clri_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                neg_q, neg_d;
  logic [PosW:0]                       r_a, r_a_n, r_b, r_b_n;
  logic                                ge_a, ge_b;

  // blend
  logic signed [WW-1:0]    w1_q, w1_d;
  logic signed [ProdW-1:0] prod_q [clri_pkg::NUM_CH];
  logic signed [ProdW-1:0] prod_d [clri_pkg::NUM_CH];
  logic signed [clri_pkg::DIFF_W-1:0] cdiff [clri_pkg::NUM_CH];
  logic signed [SumW-1:0]  sum [clri_pkg::NUM_CH];
  logic [ChW-1:0]          sat [clri_pkg::NUM_CH];

  // result register
  logic              out_vld_q, out_vld_d;
  logic [ColorW-1:0] out_q, out_d;

  // segment and weight helpers
  logic [PosW:0]   gap_full;
  logic [PosW:0]   diff_full;
  logic [PosW:0]   diff_mag;
  logic            narrow;
  logic            search_step;
  logic            load_result;

  assign wr_addr     = IdxW'(q_item_i.slot);
  assign gap_full    = {1'b0, p1_q} - {1'b0, p0_q};
  assign diff_full   = {1'b0, v_q} - {1'b0, p0_q};
  assign diff_mag    = diff_full[PosW] ? -diff_full : diff_full;
  assign narrow      = gap_full[PosW] || (gap_full[PosW-1:0] < PosW'(clri_pkg::MIN_GAP));
  assign search_step = (32'(idx_q) + 2 < 32'(count_i)) && (v_q > pos_rd_q);

  // two restoring divide steps per cycle
  assign r_a   = {rem_q, num_q[DivNW-1]};
  assign ge_a  = r_a >= {1'b0, gap_q};
  assign r_a_n = ge_a ? (r_a - {1'b0, gap_q}) : r_a;
  assign r_b   = {r_a_n[PosW-1:0], num_q[DivNW-2]};
  assign ge_b  = r_b >= {1'b0, gap_q};
  assign r_b_n = ge_b ? (r_b - {1'b0, gap_q}) : r_b;

  // per-channel colour difference and rounded, saturated sum
  always_comb begin
    for (int ch = 0; ch < clri_pkg::NUM_CH; ch++) begin
      cdiff[ch] = $signed({1'b0, c1_q[ch*ChW +: ChW]}) - $signed({1'b0, c0_q[ch*ChW +: ChW]});
      sum[ch]   = SumW'(prod_q[ch])
                + $signed({{(SumW - ChW - FracW){1'b0}}, c0_q[ch*ChW +: ChW], {FracW{1'b0}}})
                + HalfQ;
      priority if (sum[ch][SumW-1]) begin
        sat[ch] = '0;
      end else if (|sum[ch][SumW-2:FracW+ChW]) begin
        sat[ch] = '1;
      end else begin
        sat[ch] = sum[ch][FracW+ChW-1:FracW];
      end
    end
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    v_d         = v_q;
    few_d       = few_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    gap_d       = gap_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    w1_d        = w1_q;
    prod_d      = prod_q;
    out_vld_d   = out_vld_q && !pop_i;
    out_d       = out_q;
    key_vld_d   = key_vld_q;
    rd_addr     = '0;
    mem_we      = 1'b0;
    q_deq_o     = 1'b0;
    load_result = 1'b0;

    unique case (state_q)
      clri_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_deq_o = 1'b1;
          if (q_item_i.op == clri_pkg::OP_WRITE) begin
            mem_we             = 1'b1;
            key_vld_d[wr_addr] = 1'b1;
          end else begin
            v_d   = q_item_i.value;
            idx_d = '0;
            few_d = 32'(count_i) <= 2;
            if (32'(count_i) <= 2) begin
              rd_addr = '0;
              state_d = clri_pkg::ST_LO;
            end else begin
              rd_addr = IdxW'(1);
              state_d = clri_pkg::ST_SRCH;
            end
          end
        end
      end

      // read data holds the position of key idx+1
      clri_pkg::ST_SRCH: begin
        if (search_step) begin
          idx_d   = idx_q + IdxW'(1);
          rd_addr = IdxW'(32'(idx_q) + 2);
        end else begin
          p1_d    = pos_rd_q;
          rd_addr = idx_q;
          state_d = clri_pkg::ST_LO;
        end
      end

      // read data holds key idx
      clri_pkg::ST_LO: begin
        p0_d    = pos_rd_q;
        c0_d    = col_rd_q;
        rd_addr = IdxW'(32'(idx_q) + 1);
        state_d = clri_pkg::ST_HI;
      end

      // read data holds key idx+1, pick the weight source
      clri_pkg::ST_HI: begin
        c1_d = col_rd_q;
        priority if (few_q) begin
          w1_d    = WW'(v_q);
          state_d = clri_pkg::ST_MUL;
        end else if (narrow) begin
          w1_d    = '0;
          state_d = clri_pkg::ST_MUL;
        end else begin
          gap_d   = gap_full[PosW-1:0];
          neg_d   = diff_full[PosW];
          num_d   = {1'b0, diff_mag[PosW-1:0], {FracW{1'b0}}};
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = clri_pkg::ST_DIV;
        end
      end

      clri_pkg::ST_DIV: begin
        num_d = num_q << 2;
        rem_d = r_b_n[PosW-1:0];
        quo_d = {quo_q[DivNW-3:0], ge_a, ge_b};
        cnt_d = cnt_q + clri_pkg::DIV_CNT_W'(1);
        if (32'(cnt_q) == clri_pkg::DIV_STEPS - 1) begin
          state_d = clri_pkg::ST_WGT;
        end
      end

      // quotient truncates toward zero, so only the sign is restored
      clri_pkg::ST_WGT: begin
        w1_d    = neg_q ? -quo_q[WW-1:0] : quo_q[WW-1:0];
        state_d = clri_pkg::ST_MUL;
      end

      clri_pkg::ST_MUL: begin
        for (int ch = 0; ch < clri_pkg::NUM_CH; ch++) begin
          prod_d[ch] = ProdW'(w1_q) * ProdW'(cdiff[ch]);
        end
        state_d = clri_pkg::ST_SUM;
      end

      // wait for room in the result register
      clri_pkg::ST_SUM: begin
        if (!out_vld_q || pop_i) begin
          load_result = 1'b1;
          out_vld_d   = 1'b1;
          out_d       = {8'hFF - sat[3], sat[2], sat[1], sat[0]};
          state_d     = clri_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= clri_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      key_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      key_vld_q <= key_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    v_q    <= v_d;
    few_q  <= few_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    gap_q  <= gap_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    w1_q   <= w1_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  // key store, one write and one registered read port; unwritten keys read zero
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pos_mem[wr_addr] <= q_item_i.position;
      col_mem[wr_addr] <= q_item_i.color;
    end
    pos_rd_q <= key_vld_q[rd_addr] ? pos_mem[rd_addr] : '0;
    col_rd_q <= key_vld_q[rd_addr] ? col_mem[rd_addr] : '0;
  end

  assign empty_o     = !out_vld_q;
  assign out_red_o   = out_q[0*ChW +: ChW];
  assign out_green_o = out_q[1*ChW +: ChW];
  assign out_blue_o  = out_q[2*ChW +: ChW];
  assign out_alpha_o = out_q[3*ChW +: ChW];

  assign status_o.state       = state_q;
  assign status_o.search_room = 32'(idx_q) + 2 <= 32'(count_i);
  assign status_o.load_result = load_result;

endmodule

`default_nettype wire

/* rtl/core/color_ramp_interpolator_top.sv */
// color_ramp_interpolator_top: piecewise-linear colour ramp lookup
// Input items come in through push/full. operation 1 writes one key (position
// and colour) into the key store and gives no result; operation 0 maps a signed
// Q1.16 scalar to an RGBA colour and gives one result on the result side.
// Results are read through empty/pop; the oldest result sits on out_*_o while
// empty is low. Configuration (key_count, invert_ramp) is written through
// cfg_valid_i/cfg_ready_o with cfg_index_i selecting the register; ready is
// always high.
// Back engine: a key write is stored from the idle state; a map item reads
// keys idx and idx+1 (LO, HI) and takes as weight the scalar with two keys or
// fewer, zero when the segment gap is narrow, else the radix-4 divider result
// (DIV, WGT), then multiplies and sums (MUL, SUM). With more than two keys the
// search (SRCH) first reads one key position per cycle from the key store
// port, stepping past up to key_count-2 segments.
// Reset clears all keys to zero, sets key_count to 2 and invert_ramp to 0.
// When pop is held low the result register holds, the engine waits with its
// finished result, the two-entry item queue fills and then full rises.
// depends on clri_pkg, clri_front, clri_queue, clri_back
`default_nettype none

module color_ramp_interpolator_top #(
  parameter int MAX_KEYS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input item queue side
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 operation_i,
  input  logic signed [clri_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [clri_pkg::SLOT_W-1:0]          key_slot_i,
  input  logic [clri_pkg::POS_W-1:0]           key_position_i,
  input  logic [clri_pkg::CH_W-1:0]            key_red_i,
  input  logic [clri_pkg::CH_W-1:0]            key_green_i,
  input  logic [clri_pkg::CH_W-1:0]            key_blue_i,
  input  logic [clri_pkg::CH_W-1:0]            key_alpha_i,
  // result queue side
  output logic                                 empty,
  input  logic                                 pop,
  output logic [clri_pkg::CH_W-1:0]            out_red_o,
  output logic [clri_pkg::CH_W-1:0]            out_green_o,
  output logic [clri_pkg::CH_W-1:0]            out_blue_o,
  output logic [clri_pkg::CH_W-1:0]            out_alpha_o,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [clri_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [clri_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic [clri_pkg::COUNT_W-1:0] key_count_q;
  logic                         invert_q;
  logic                         enq;
  clri_pkg::clri_item_t         front_item;
  clri_pkg::clri_item_t         head_item;
  logic                         head_valid;
  logic                         deq;
  clri_pkg::clri_status_t       st;

  assign cfg_ready_o = 1'b1;

  // configuration registers, key count saturates to the store depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= clri_pkg::COUNT_W'(2);
      invert_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (clri_pkg::clri_reg_e'(cfg_index_i))
        clri_pkg::REG_KEY_COUNT: begin
          if (32'(cfg_data_i) > MAX_KEYS) begin
            key_count_q <= clri_pkg::COUNT_W'(MAX_KEYS);
          end else begin
            key_count_q <= cfg_data_i[clri_pkg::COUNT_W-1:0];
          end
        end
        clri_pkg::REG_INVERT: begin
          invert_q <= cfg_data_i[0];
        end
        default: begin
          invert_q <= invert_q;
        end
      endcase
    end
  end

  // front: accept and classify
  clri_front #(
    .MAX_KEYS(MAX_KEYS)
  ) u_front (
    .push_i        (push),
    .full_i        (full),
    .invert_i      (invert_q),
    .operation_i   (operation_i),
    .sample_value_i(sample_value_i),
    .key_slot_i    (key_slot_i),
    .key_position_i(key_position_i),
    .key_red_i     (key_red_i),
    .key_green_i   (key_green_i),
    .key_blue_i    (key_blue_i),
    .key_alpha_i   (key_alpha_i),
    .enq_o         (enq),
    .item_o        (front_item)
  );

  // queue between front and back
  clri_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .enq_i  (enq),
    .item_i (front_item),
    .full_o (full),
    .deq_i  (deq),
    .valid_o(head_valid),
    .item_o (head_item)
  );

  // back: key store, search, divide, blend
  clri_back #(
    .MAX_KEYS(MAX_KEYS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .count_i    (key_count_q),
    .q_valid_i  (head_valid),
    .q_item_i   (head_item),
    .q_deq_o    (deq),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .out_alpha_o(out_alpha_o),
    .status_o   (st)
  );

  // key count never exceeds the store depth
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(key_count_q) <= MAX_KEYS)
    else $error("key count above store depth");

  // search never reads past the last key in use
  a_search_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.state == clri_pkg::ST_SRCH |-> st.search_room)
    else $error("segment search ran past the keys in use");

  // a result is only loaded when the result register is free or being taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.load_result |-> (empty || pop))
    else $error("result register overwritten");

  // divider only leaves towards the weight fix-up
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.state == clri_pkg::ST_DIV |=>
      (st.state == clri_pkg::ST_DIV || st.state == clri_pkg::ST_WGT))
    else $error("divider left early");

endmodule

`default_nettype wire
